### rtl/nsc_pkg.sv
// shared types, constants and character helpers for the nmea sentence checker
`default_nettype none

package nsc_pkg;

    localparam int LINE_CAPACITY = 256;
    localparam int POS_W         = $clog2(LINE_CAPACITY);

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_LAST    = POS_W'(LINE_CAPACITY - 1);
    localparam t_pos POS_MIN_HDR = POS_W'(7);
    localparam t_pos POS_COMMA   = POS_W'(6);
    localparam t_pos POS_LTR_END = POS_W'(5);

    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_STAR     = 8'h2A;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_NOT_NMEA = 3'd1,
        EV_NMEA_OK  = 3'd2,
        EV_NMEA_BAD = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_INVALID  = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        HEX_NONE = 2'd0,
        HEX_ONE  = 2'd1,
        HEX_TWO  = 2'd2
    } t_hex_status;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex_digit;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  computed_sum;
        logic [7:0]  received_sum;
        logic [7:0]  line_length;
        logic [31:0] byte_count;
        logic [31:0] line_count;
        logic [31:0] nmea_count;
        logic [31:0] overflow_count;
        logic [31:0] invalid_count;
    } t_result;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic t_hex_digit hex_digit(input logic [7:0] c);
        t_hex_digit d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            d.value = 4'(c - 8'h30);
        end else if ((c >= 8'h41) && (c <= 8'h46)) begin
            d.value = 4'(c - 8'h37);
        end else if ((c >= 8'h61) && (c <= 8'h66)) begin
            d.value = 4'(c - 8'h57);
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/nsc_line_tracker.sv
// per-byte line parser: header check, running xor, hex checksum and counters
`default_nettype none

module nsc_line_tracker
    import nsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output t_result         o_result
);

    t_pos        r_pos, n_pos;
    logic        r_header_good, n_header_good;
    logic [7:0]  r_xor, n_xor;
    logic        r_star, n_star;
    logic [1:0]  r_cas, n_cas;
    logic [7:0]  r_hex, n_hex;
    t_hex_status r_hex_status, n_hex_status;
    logic [31:0] r_bytes, n_bytes;
    logic [31:0] r_lines, n_lines;
    logic [31:0] r_nmea, n_nmea;
    logic [31:0] r_overflows, n_overflows;
    logic [31:0] r_invalid, n_invalid;

    always_comb begin
        logic        printable;
        logic        eol;
        logic        nmea;
        logic        sum_ok;
        logic        length_set;
        t_pos        b_pos;
        logic        b_header_good;
        logic [7:0]  b_xor;
        logic        b_star;
        logic [1:0]  b_cas;
        logic [7:0]  b_hex;
        t_hex_status b_hex_status;
        t_hex_digit  d;
        t_event      ev;
        logic [7:0]  csum;
        logic [7:0]  rsum;
        logic [7:0]  len;

        n_pos         = r_pos;
        n_header_good = r_header_good;
        n_xor         = r_xor;
        n_star        = r_star;
        n_cas         = r_cas;
        n_hex         = r_hex;
        n_hex_status  = r_hex_status;
        n_bytes       = r_bytes + 32'd1;
        n_lines       = r_lines;
        n_nmea        = r_nmea;
        n_overflows   = r_overflows;
        n_invalid     = r_invalid;
        ev            = EV_NONE;
        csum          = 8'd0;
        rsum          = 8'd0;
        length_set    = 1'b0;
        len           = 8'd0;

        printable = (i_byte >= CH_PRINT_LO) && (i_byte <= CH_PRINT_HI);
        eol       = (i_byte == CH_CR) || (i_byte == CH_LF);
        nmea      = r_header_good && (r_pos >= POS_MIN_HDR);
        sum_ok    = !r_star || ((r_cas >= 2'd2) && (r_hex_status != HEX_NONE) &&
                                (r_xor == r_hex));
        d         = hex_digit(i_byte);

        // a dollar sign restarts the line before it is appended
        if (i_byte == CH_DOLLAR) begin
            b_pos         = '0;
            b_header_good = 1'b0;
            b_xor         = 8'd0;
            b_star        = 1'b0;
            b_cas         = 2'd0;
            b_hex         = 8'd0;
            b_hex_status  = HEX_NONE;
        end else begin
            b_pos         = r_pos;
            b_header_good = r_header_good;
            b_xor         = r_xor;
            b_star        = r_star;
            b_cas         = r_cas;
            b_hex         = r_hex;
            b_hex_status  = r_hex_status;
        end

        if (!printable && !eol) begin
            n_invalid = r_invalid + 32'd1;
            ev        = EV_INVALID;
        end else if (eol) begin
            if (r_pos != '0) begin
                n_lines    = r_lines + 32'd1;
                csum       = r_xor;
                rsum       = r_hex;
                len        = 8'(32'(r_pos));
                length_set = 1'b1;
                if (!nmea) begin
                    ev = EV_NOT_NMEA;
                end else begin
                    n_nmea = r_nmea + 32'd1;
                    ev     = sum_ok ? EV_NMEA_OK : EV_NMEA_BAD;
                end
                n_pos         = '0;
                n_header_good = 1'b0;
                n_xor         = 8'd0;
                n_star        = 1'b0;
                n_cas         = 2'd0;
                n_hex         = 8'd0;
                n_hex_status  = HEX_NONE;
            end
        end else if (b_pos < POS_LAST) begin
            n_header_good = b_header_good;
            n_xor         = b_xor;
            n_star        = b_star;
            n_cas         = b_cas;
            n_hex         = b_hex;
            n_hex_status  = b_hex_status;
            if (b_pos == '0) begin
                n_header_good = (i_byte == CH_DOLLAR);
            end else if (b_pos <= POS_LTR_END) begin
                n_header_good = b_header_good && is_letter(i_byte);
            end else if (b_pos == POS_COMMA) begin
                n_header_good = b_header_good && (i_byte == CH_COMMA);
            end
            if (b_pos != '0) begin
                if (!b_star) begin
                    if (i_byte == CH_STAR) begin
                        n_star = 1'b1;
                    end else begin
                        n_xor = b_xor ^ i_byte;
                    end
                end else begin
                    if (b_cas == 2'd0) begin
                        if (d.valid) begin
                            n_hex        = {4'd0, d.value};
                            n_hex_status = HEX_ONE;
                        end
                    end else if ((b_cas == 2'd1) && (b_hex_status == HEX_ONE) && d.valid) begin
                        n_hex        = {b_hex[3:0], d.value};
                        n_hex_status = HEX_TWO;
                    end
                    if (b_cas != 2'd3) begin
                        n_cas = b_cas + 2'd1;
                    end
                end
            end
            n_pos = b_pos + POS_W'(1);
        end else begin
            n_overflows   = r_overflows + 32'd1;
            ev            = EV_OVERFLOW;
            n_pos         = '0;
            n_header_good = 1'b0;
            n_xor         = 8'd0;
            n_star        = 1'b0;
            n_cas         = 2'd0;
            n_hex         = 8'd0;
            n_hex_status  = HEX_NONE;
        end

        if (!length_set) begin
            len = 8'(32'(n_pos));
        end

        o_result.event_res      = ev;
        o_result.computed_sum   = csum;
        o_result.received_sum   = rsum;
        o_result.line_length    = len;
        o_result.byte_count     = n_bytes;
        o_result.line_count     = n_lines;
        o_result.nmea_count     = n_nmea;
        o_result.overflow_count = n_overflows;
        o_result.invalid_count  = n_invalid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_header_good <= 1'b0;
            r_xor         <= 8'd0;
            r_star        <= 1'b0;
            r_cas         <= 2'd0;
            r_hex         <= 8'd0;
            r_hex_status  <= HEX_NONE;
            r_bytes       <= 32'd0;
            r_lines       <= 32'd0;
            r_nmea        <= 32'd0;
            r_overflows   <= 32'd0;
            r_invalid     <= 32'd0;
        end else if (i_step) begin
            r_pos         <= n_pos;
            r_header_good <= n_header_good;
            r_xor         <= n_xor;
            r_star        <= n_star;
            r_cas         <= n_cas;
            r_hex         <= n_hex;
            r_hex_status  <= n_hex_status;
            r_bytes       <= n_bytes;
            r_lines       <= n_lines;
            r_nmea        <= n_nmea;
            r_overflows   <= n_overflows;
            r_invalid     <= n_invalid;
        end
    end

endmodule

`default_nettype wire

### rtl/nmea_sentence_checker_unit.sv
// nmea sentence checker: each input transaction is registered, parsed and registered again as a result
// throughput one byte per cycle unless downstream stalls, input register feeds line tracker feeds result register
// the input register refills in the same cycle its byte moves on, so stall only
// rises while a result is held back by downstream stall
// synchronous active-low reset clears both valid flags, line state and all counters
`default_nettype none

module nmea_sentence_checker_unit
    import nsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_event_res,
    output logic [7:0]       o_computed_sum,
    output logic [7:0]       o_received_sum,
    output logic [7:0]       o_line_length,
    output logic [31:0]      o_byte_count,
    output logic [31:0]      o_line_count,
    output logic [31:0]      o_nmea_count,
    output logic [31:0]      o_overflow_count,
    output logic [31:0]      o_invalid_count
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    logic       out_ready;
    logic       in_accept;
    logic       step;

    assign out_ready = !r_out_valid || !i_stall;
    assign step      = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;
    assign in_accept = i_valid && !o_stall;

    nsc_line_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
        if (step) begin
            r_res <= n_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_res      = r_res.event_res;
    assign o_computed_sum   = r_res.computed_sum;
    assign o_received_sum   = r_res.received_sum;
    assign o_line_length    = r_res.line_length;
    assign o_byte_count     = r_res.byte_count;
    assign o_line_count     = r_res.line_count;
    assign o_nmea_count     = r_res.nmea_count;
    assign o_overflow_count = r_res.overflow_count;
    assign o_invalid_count  = r_res.invalid_count;

endmodule

`default_nettype wire

### rtl/nsc_checker.sv
// port-level checks for the nmea sentence checker, bound to the top level
`default_nettype none

module nsc_checker
    import nsc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [7:0]  i_rx_byte,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_event_res,
    input wire logic [7:0]  o_computed_sum,
    input wire logic [7:0]  o_received_sum,
    input wire logic [7:0]  o_line_length,
    input wire logic [31:0] o_byte_count,
    input wire logic [31:0] o_line_count,
    input wire logic [31:0] o_nmea_count,
    input wire logic [31:0] o_overflow_count,
    input wire logic [31:0] o_invalid_count
);

    logic        r_seen;
    logic [31:0] r_last_bytes;
    logic        out_xfer;

    assign out_xfer = o_valid && !i_stall;

    // remember the byte count of the previous output transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_last_bytes <= 32'd0;
        end else if (out_xfer) begin
            r_seen       <= 1'b1;
            r_last_bytes <= o_byte_count;
        end
    end

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_byte_count) && $stable(o_event_res))
        else $error("stalled result changed");

    a_byte_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen |-> o_byte_count == r_last_bytes + 32'd1)
        else $error("byte count did not advance by one per result");

    a_overflow_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_OVERFLOW) |-> (o_line_length == 8'd0) &&
        (o_computed_sum == 8'd0) && (o_received_sum == 8'd0))
        else $error("overflow result carries line data");

    a_nmea_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_event_res == EV_NMEA_OK) || (o_event_res == EV_NMEA_BAD)) |->
        (o_line_length >= 8'd7) && (o_nmea_count != 32'd0) && (o_line_count != 32'd0))
        else $error("nmea result without a full header");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_res <= EV_INVALID))
        else $error("result event code out of range");

endmodule

bind nmea_sentence_checker_unit nsc_checker u_nsc_checker (.*);

`default_nettype wire

### verif/nsc_result_checker.sv
// line tracker predictor and result scoreboard for the nmea sentence checker unit
`timescale 1ns / 1ps

module nsc_result_checker
    import nsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_res,
    input  logic [7:0]  i_computed_sum,
    input  logic [7:0]  i_received_sum,
    input  logic [7:0]  i_line_length,
    input  logic [31:0] i_byte_count,
    input  logic [31:0] i_line_count,
    input  logic [31:0] i_nmea_count,
    input  logic [31:0] i_overflow_count,
    input  logic [31:0] i_invalid_count,
    output int          o_error_count,
    output int          o_pending,
    output int          o_checked
);

    // predicted line state
    int unsigned line_pos;
    bit          hdr_ok;
    bit          star_hit;
    logic [7:0]  xor_acc;
    logic [7:0]  hex_acc;
    int unsigned after_star;
    t_hex_status hex_state;

    // predicted wrapping totals
    logic [31:0] n_bytes;
    logic [31:0] n_lines;
    logic [31:0] n_nmea;
    logic [31:0] n_over;
    logic [31:0] n_invalid;

    t_result expected_results[$];

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        o_checked     = 0;
    end

    task automatic restart_line();
        line_pos   = 0;
        hdr_ok     = 1'b0;
        star_hit   = 1'b0;
        xor_acc    = 8'h00;
        hex_acc    = 8'h00;
        after_star = 0;
        hex_state  = HEX_NONE;
    endtask

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
        return -1;
    endfunction

    task automatic take_char(input logic [7:0] c);
        int d;
        if (line_pos == 0) begin
            hdr_ok = (c == CH_DOLLAR);
        end else if (line_pos <= 5) begin
            if (!((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))) hdr_ok = 1'b0;
        end else if (line_pos == 6) begin
            if (c != CH_COMMA) hdr_ok = 1'b0;
        end
        if (line_pos >= 1) begin
            if (!star_hit) begin
                if (c == CH_STAR) star_hit = 1'b1;
                else xor_acc = xor_acc ^ c;
            end else begin
                d = nibble_of(c);
                if (after_star == 0) begin
                    if (d >= 0) begin
                        hex_acc   = 8'(d);
                        hex_state = HEX_ONE;
                    end
                end else if (after_star == 1 && hex_state == HEX_ONE && d >= 0) begin
                    hex_acc   = {hex_acc[3:0], 4'(d)};
                    hex_state = HEX_TWO;
                end
                // only the first two characters after the star matter
                if (after_star < 3) after_star++;
            end
        end
        line_pos++;
    endtask

    task automatic predict_byte(input logic [7:0] c, output t_result r);
        bit is_eol;
        bit printable;
        bit len_set;
        bit sum_ok;
        is_eol    = (c == CH_CR) || (c == CH_LF);
        printable = (c >= CH_PRINT_LO) && (c <= CH_PRINT_HI);
        len_set   = 1'b0;
        r         = '0;
        r.event_res = EV_NONE;
        n_bytes++;
        if (!(printable || is_eol)) begin
            n_invalid++;
            r.event_res = EV_INVALID;
        end else if (is_eol) begin
            if (line_pos > 0) begin
                n_lines++;
                r.computed_sum = xor_acc;
                r.received_sum = hex_acc;
                r.line_length  = 8'(line_pos);
                len_set        = 1'b1;
                if (!(hdr_ok && line_pos >= 7)) begin
                    r.event_res = EV_NOT_NMEA;
                end else begin
                    sum_ok = !star_hit || (after_star >= 2 && hex_state != HEX_NONE &&
                                           xor_acc == hex_acc);
                    n_nmea++;
                    r.event_res = sum_ok ? EV_NMEA_OK : EV_NMEA_BAD;
                end
                restart_line();
            end
        end else begin
            if (c == CH_DOLLAR) restart_line();
            if (line_pos < LINE_CAPACITY - 1) begin
                take_char(c);
            end else begin
                // line full: the byte and the whole line are dropped
                n_over++;
                r.event_res = EV_OVERFLOW;
                restart_line();
            end
        end
        if (!len_set) r.line_length = 8'(line_pos);
        r.byte_count     = n_bytes;
        r.line_count     = n_lines;
        r.nmea_count     = n_nmea;
        r.overflow_count = n_over;
        r.invalid_count  = n_invalid;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            restart_line();
            n_bytes   = '0;
            n_lines   = '0;
            n_nmea    = '0;
            n_over    = '0;
            n_invalid = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    o_error_count++;
                    $display("%0t: result transaction with nothing expected, expected none, actual event %0d",
                             $time, i_event_res);
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    check_field("event_res", 32'(want.event_res), 32'(i_event_res));
                    check_field("computed_sum", 32'(want.computed_sum), 32'(i_computed_sum));
                    check_field("received_sum", 32'(want.received_sum), 32'(i_received_sum));
                    check_field("line_length", 32'(want.line_length), 32'(i_line_length));
                    check_field("byte_count", want.byte_count, i_byte_count);
                    check_field("line_count", want.line_count, i_line_count);
                    check_field("nmea_count", want.nmea_count, i_nmea_count);
                    check_field("overflow_count", want.overflow_count, i_overflow_count);
                    check_field("invalid_count", want.invalid_count, i_invalid_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_byte(i_rx_byte, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### verif/testbench.sv
// top of the nmea sentence checker testbench: clock, reset, byte stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import nsc_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_CYCLES      = 64;
    localparam int RANDOM_PER_PHASE = 60;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        in_stall;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_res;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic [7:0]  line_length;
    logic [31:0] byte_count;
    logic [31:0] line_count;
    logic [31:0] nmea_count;
    logic [31:0] overflow_count;
    logic [31:0] invalid_count;

    int error_count;
    int pending;
    int checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int bytes_sent     = 0;
    int cycle_count    = 0;

    logic [7:0] tx_bytes[$];

    nmea_sentence_checker_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_rx_byte        (rx_byte),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_event_res      (event_res),
        .o_computed_sum   (computed_sum),
        .o_received_sum   (received_sum),
        .o_line_length    (line_length),
        .o_byte_count     (byte_count),
        .o_line_count     (line_count),
        .o_nmea_count     (nmea_count),
        .o_overflow_count (overflow_count),
        .o_invalid_count  (invalid_count)
    );

    nsc_result_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_event_res      (event_res),
        .i_computed_sum   (computed_sum),
        .i_received_sum   (received_sum),
        .i_line_length    (line_length),
        .i_byte_count     (byte_count),
        .i_line_count     (line_count),
        .i_nmea_count     (nmea_count),
        .i_overflow_count (overflow_count),
        .i_invalid_count  (invalid_count),
        .o_error_count    (error_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL nmea_sentence_checker_unit");
            $finish;
        end
    end

    // result side: random stall, plus a long hold-off whenever one is requested
    always @(negedge clk) begin
        if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic transmit_queued();
        while (tx_bytes.size() > 0) send_byte(tx_bytes.pop_front());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] random_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    // printable filler that neither restarts the line nor opens a checksum
    function automatic logic [7:0] random_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
        while (c == CH_STAR || c == CH_DOLLAR);
        return c;
    endfunction

    task automatic push_line_end();
        case ($urandom_range(0, 2))
            0: tx_bytes.push_back(CH_CR);
            1: tx_bytes.push_back(CH_LF);
            default: begin
                tx_bytes.push_back(CH_CR);
                tx_bytes.push_back(CH_LF);
            end
        endcase
    endtask

    task automatic compose_sentence();
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] wrong;
        bit         lower;
        int         style;
        sum = 8'h00;
        tx_bytes.push_back(CH_DOLLAR);
        repeat (5) begin
            c = random_letter();
            tx_bytes.push_back(c);
            sum ^= c;
        end
        tx_bytes.push_back(CH_COMMA);
        sum ^= CH_COMMA;
        repeat ($urandom_range(0, 18)) begin
            c = random_text_char();
            tx_bytes.push_back(c);
            sum ^= c;
        end
        lower = $urandom_range(0, 1);
        style = $urandom_range(0, 11);
        if (style != 0) begin
            tx_bytes.push_back(CH_STAR);
            case (style)
                7: begin
                    wrong = sum ^ 8'($urandom_range(1, 255));
                    tx_bytes.push_back(hex_char(wrong[7:4], lower));
                    tx_bytes.push_back(hex_char(wrong[3:0], lower));
                end
                8: begin
                    // single digit, maybe followed by a non-hex character
                    tx_bytes.push_back(hex_char(sum[3:0], lower));
                    if ($urandom_range(0, 1)) tx_bytes.push_back(CH_COMMA);
                end
                9: ;
                10: begin
                    // leading space before the digits is not accepted
                    tx_bytes.push_back(CH_PRINT_LO);
                    tx_bytes.push_back(hex_char(sum[7:4], lower));
                    tx_bytes.push_back(hex_char(sum[3:0], lower));
                end
                11: begin
                    // 0x prefix: only the zero counts as a digit
                    tx_bytes.push_back(8'h30);
                    tx_bytes.push_back(8'h78);
                    tx_bytes.push_back(hex_char(sum[7:4], lower));
                end
                default: begin
                    tx_bytes.push_back(hex_char(sum[7:4], lower));
                    tx_bytes.push_back(hex_char(sum[3:0], lower));
                end
            endcase
        end
        push_line_end();
    endtask

    task automatic compose_broken_sentence();
        int idx;
        compose_sentence();
        idx = $urandom_range(0, tx_bytes.size() - 1);
        case ($urandom_range(0, 2))
            0: tx_bytes[idx] = 8'($urandom_range(0, 255));
            1: tx_bytes.insert(idx, CH_DOLLAR);
            default: tx_bytes.delete(idx);
        endcase
    endtask

    task automatic run_random_phase(input int quota);
        int start;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                compose_sentence();
            end else if (pick < 80) begin
                compose_broken_sentence();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 10)) tx_bytes.push_back(random_text_char());
                push_line_end();
            end
            transmit_queued();
        end
    endtask

    initial begin
        string      talker;
        logic [7:0] sum;
        int         i;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: invalid extremes, empty line end, short lines, minimal nmea line
        tx_bytes = '{8'h00, 8'hFF, 8'h7F, 8'h1F, CH_CR, 8'h78, CH_LF,
                     CH_DOLLAR, 8'h41, 8'h42, CH_LF, CH_DOLLAR};
        talker = "GPRMC,";
        sum = 8'h00;
        for (i = 0; i < talker.len(); i++) begin
            tx_bytes.push_back(8'(talker[i]));
            sum ^= 8'(talker[i]);
        end
        tx_bytes.push_back(CH_STAR);
        tx_bytes.push_back(hex_char(sum[7:4], 1'b0));
        tx_bytes.push_back(hex_char(sum[3:0], 1'b1));
        tx_bytes.push_back(CH_CR);
        transmit_queued();

        run_random_phase(RANDOM_PER_PHASE);
        send_idle_pct = 46;
        run_random_phase(RANDOM_PER_PHASE);
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        run_random_phase(RANDOM_PER_PHASE);
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        run_random_phase(RANDOM_PER_PHASE);

        // long receiver hold-off with the sender pushing back to back
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        run_random_phase(40);
        wait_drained();

        // line of full capacity, then one that overflows
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        tx_bytes.push_back(CH_DOLLAR);
        repeat (5) tx_bytes.push_back(random_letter());
        tx_bytes.push_back(CH_COMMA);
        while (tx_bytes.size() < LINE_CAPACITY - 1) tx_bytes.push_back(random_text_char());
        tx_bytes.push_back(CH_CR);
        repeat (LINE_CAPACITY) tx_bytes.push_back(random_text_char());
        repeat (3) tx_bytes.push_back(random_text_char());
        tx_bytes.push_back(CH_LF);
        transmit_queued();

        wait_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d bytes: directed cases, random sentences under four idle/stall mixes,",
                 bytes_sent);
        $display("a long result hold-off, a drain pause, full-length and overflowing lines; %0d checked",
                 checked);
        if (error_count == 0) begin
            $display("PASS nmea_sentence_checker_unit");
        end else begin
            $display("FAIL nmea_sentence_checker_unit");
        end
        $finish;
    end

endmodule
